// ----- hdl/pm1_pkg.sv -----
// ----------------------------------------------------------------------------
// pm1_pkg: shared types and constants for the p-1 factor search core
// payload structs, status codes, search phases and controller/datapath links
// ----------------------------------------------------------------------------
package pm1_pkg;

  localparam logic [2:0] ST_SEARCHING = 3'd0;
  localparam logic [2:0] ST_FOUND1    = 3'd1;
  localparam logic [2:0] ST_FOUND2    = 3'd2;
  localparam logic [2:0] ST_NOFACTOR  = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;
  localparam logic [2:0] ST_UNAVAIL   = 3'd5;
  localparam logic [2:0] ST_BADMOD    = 3'd6;

  localparam logic [1:0] CFG_MODULUS     = 2'd0;
  localparam logic [1:0] CFG_BOUND_ONE   = 2'd1;
  localparam logic [1:0] CFG_PRIME_LIMIT = 2'd2;

  localparam logic [31:0] DEF_BOUND_ONE = 32'd1000000;
  localparam logic [38:0] MAX_BOUND_TWO = 39'd10000000;
  localparam logic [38:0] B2_MULT       = 39'd100;
  localparam logic [63:0] START_BASE    = 64'd2;

  localparam logic CMD_START = 1'b0;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] prime;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] factor;
    logic [63:0] cofactor;
    logic        bound_clipped;
  } out_t;

  typedef struct packed {
    logic       load_item;
    logic       do_start;
    logic       res_we;
    logic [2:0] res_code;
    logic       phase_we;
    phase_t     phase_val;
    logic       pk_load;
    logic       prod_calc;
    logic       pk_take;
    logic       e_load_pk;
    logic       e_load_p;
    logic       e_drop_lsb;
    logic       e_shift;
    logic       e_clr;
    logic       div_go;
    logic       div_quot;
    logic       b_load_rem;
    logic       pow_init;
    logic       mul_go;
    logic       mul_sq;
    logic       r_load;
    logic       b_load;
    logic       gcd_init;
    logic       gcd_step;
    logic       base_load;
    logic       found_we;
  } dp_cmd_t;

  typedef struct packed {
    logic   item_cmd;
    logic   item_last;
    phase_t phase;
    logic   mod_bad;
    logic   p_le_b1;
    logic   p_lt2;
    logic   b2_le_b1;
    logic   p_gt_b2;
    logic   prod_le_b1;
    logic   e_zero;
    logic   e_lsb;
    logic   e_hi_zero;
    logic   mul_busy;
    logic   div_busy;
    logic   a_zero;
    logic   g_proper;
    logic   g_eq_n;
  } dp_stat_t;

endpackage

// ----- hdl/pollard_pminus1_u64_core.sv -----
// ----------------------------------------------------------------------------
// pollard_pminus1_u64_core: Pollard p-1 factor search on a 64-bit modulus
// takes start and prime transactions, returns one result per transaction
// ----------------------------------------------------------------------------
// start and ignored transactions go from decode straight to the output register
// a prime takes a reduction of the base, up to 63 modular multiplies
// (bit-serial modmul), a binary gcd and a division when a factor shows up
// throughput: one transaction at a time; the output register frees the input
// reset: synchronous, clears config, search phase, bounds and base to 2
module pollard_pminus1_u64_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  pm1_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pm1_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  pm1_pkg::dp_cmd_t  cmd;
  pm1_pkg::dp_stat_t stat;
  pm1_pkg::out_t     result;
  logic              idle;
  logic              out_load;
  logic              out_free;
  logic              in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  pm1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .out_load (out_load)
  );

  pm1_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a transaction was in progress");

  a_factor_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !(out_data.status == pm1_pkg::ST_FOUND1 ||
                   out_data.status == pm1_pkg::ST_FOUND2)
    |-> out_data.factor == 64'd0 && out_data.cofactor == 64'd0)
    else $error("factor reported without a found status");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == pm1_pkg::ST_FOUND1 ||
                  out_data.status == pm1_pkg::ST_FOUND2)
    |-> out_data.factor > 64'd1 && out_data.cofactor != 64'd0)
    else $error("found status with an improper factor");
`endif

endmodule

// ----- hdl/pm1_ctrl.sv -----
// ----------------------------------------------------------------------------
// pm1_ctrl: search sequencer
// steps one transaction through decode, prime power, modular power and gcd
// ----------------------------------------------------------------------------
module pm1_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              out_free,
  input  pm1_pkg::dp_stat_t stat,
  output pm1_pkg::dp_cmd_t  cmd,
  output logic              idle,
  output logic              out_load
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DECODE   = 13'b0000000000010,
    S_PK_MUL   = 13'b0000000000100,
    S_PK_CHK   = 13'b0000000001000,
    S_RED      = 13'b0000000010000,
    S_POW      = 13'b0000000100000,
    S_MUL_R    = 13'b0000001000000,
    S_MUL_B    = 13'b0000010000000,
    S_GCD_INIT = 13'b0000100000000,
    S_GCD      = 13'b0001000000000,
    S_EVAL     = 13'b0010000000000,
    S_QUOT     = 13'b0100000000000,
    S_FINISH   = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   stage_two, stage_two_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage_two <= 1'b0;
    end else begin
      state     <= state_next;
      stage_two <= stage_two_next;
    end
  end

  assign idle     = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && out_free;

  always_comb begin
    cmd            = '0;
    cmd.phase_val  = pm1_pkg::PH_IDLE;
    state_next     = state;
    stage_two_next = stage_two;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        if (stat.item_cmd == pm1_pkg::CMD_START) begin
          cmd.do_start = 1'b1;
        end else if (stat.phase == pm1_pkg::PH_IDLE || stat.phase == pm1_pkg::PH_DONE) begin
          cmd.res_we   = 1'b1;
          cmd.res_code = pm1_pkg::ST_IGNORED;
        end else if (stat.mod_bad) begin
          cmd.res_we    = 1'b1;
          cmd.res_code  = pm1_pkg::ST_BADMOD;
          cmd.phase_we  = 1'b1;
          cmd.phase_val = pm1_pkg::PH_IDLE;
        end else if (stat.phase == pm1_pkg::PH_ONE && stat.p_le_b1) begin
          if (stat.p_lt2) begin
            // skipped prime, only the last flag matters
            if (stat.item_last) begin
              cmd.res_we    = 1'b1;
              cmd.res_code  = pm1_pkg::ST_NOFACTOR;
              cmd.phase_we  = 1'b1;
              cmd.phase_val = pm1_pkg::PH_DONE;
            end
          end else begin
            cmd.pk_load    = 1'b1;
            stage_two_next = 1'b0;
            state_next     = S_PK_MUL;
          end
        end else if ((stat.phase == pm1_pkg::PH_ONE && stat.b2_le_b1) || stat.p_gt_b2) begin
          cmd.res_we    = 1'b1;
          cmd.res_code  = pm1_pkg::ST_NOFACTOR;
          cmd.phase_we  = 1'b1;
          cmd.phase_val = pm1_pkg::PH_DONE;
        end else begin
          cmd.phase_we   = 1'b1;
          cmd.phase_val  = pm1_pkg::PH_TWO;
          cmd.e_load_p   = 1'b1;
          cmd.div_go     = 1'b1;
          stage_two_next = 1'b1;
          state_next     = S_RED;
        end
      end
      S_PK_MUL: begin
        cmd.prod_calc = 1'b1;
        state_next    = S_PK_CHK;
      end
      S_PK_CHK: begin
        if (stat.prod_le_b1) begin
          cmd.pk_take = 1'b1;
          state_next  = S_PK_MUL;
        end else begin
          cmd.e_load_pk = 1'b1;
          cmd.div_go    = 1'b1;
          state_next    = S_RED;
        end
      end
      S_RED: begin
        if (!stat.div_busy) begin
          cmd.b_load_rem = 1'b1;
          cmd.pow_init   = 1'b1;
          state_next     = S_POW;
        end
      end
      S_POW: begin
        if (stat.e_zero) begin
          state_next = S_GCD_INIT;
        end else if (stat.e_lsb) begin
          cmd.mul_go = 1'b1;
          state_next = S_MUL_R;
        end else if (stat.e_hi_zero) begin
          // final squaring would be unused
          cmd.e_clr = 1'b1;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sq = 1'b1;
          state_next = S_MUL_B;
        end
      end
      S_MUL_R: begin
        if (!stat.mul_busy) begin
          cmd.r_load     = 1'b1;
          cmd.e_drop_lsb = 1'b1;
          state_next     = S_POW;
        end
      end
      S_MUL_B: begin
        if (!stat.mul_busy) begin
          cmd.b_load  = 1'b1;
          cmd.e_shift = 1'b1;
          state_next  = S_POW;
        end
      end
      S_GCD_INIT: begin
        cmd.gcd_init  = 1'b1;
        cmd.base_load = !stage_two;
        state_next    = S_GCD;
      end
      S_GCD: begin
        if (stat.a_zero) begin
          state_next = S_EVAL;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_EVAL: begin
        state_next = S_FINISH;
        if (stat.g_proper) begin
          cmd.div_go   = 1'b1;
          cmd.div_quot = 1'b1;
          state_next   = S_QUOT;
        end else if (stat.g_eq_n || stat.item_last) begin
          cmd.res_we    = 1'b1;
          cmd.res_code  = pm1_pkg::ST_NOFACTOR;
          cmd.phase_we  = 1'b1;
          cmd.phase_val = pm1_pkg::PH_DONE;
        end
      end
      S_QUOT: begin
        if (!stat.div_busy) begin
          cmd.found_we  = 1'b1;
          cmd.res_we    = 1'b1;
          cmd.res_code  = stage_two ? pm1_pkg::ST_FOUND2 : pm1_pkg::ST_FOUND1;
          cmd.phase_we  = 1'b1;
          cmd.phase_val = pm1_pkg::PH_DONE;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/pm1_dp.sv -----
// ----------------------------------------------------------------------------
// pm1_dp: search datapath
// config and search state, bit-serial modmul, restoring divider, binary gcd
// ----------------------------------------------------------------------------
module pm1_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  pm1_pkg::in_t      item,
  input  pm1_pkg::dp_cmd_t  cmd,
  output pm1_pkg::dp_stat_t stat,
  output pm1_pkg::out_t     result
);

  // configuration
  logic [63:0] modulus;
  logic [31:0] bound_one;
  logic [31:0] prime_limit;

  // search state
  pm1_pkg::phase_t phase;
  logic [31:0]     eb1;
  logic [31:0]     eb2;
  logic            clipped;
  logic [63:0]     base;

  // current transaction and its result
  logic        it_cmd;
  logic [31:0] it_prime;
  logic        it_last;
  logic [2:0]  res_status;
  logic [63:0] res_factor;
  logic [63:0] res_cofactor;

  // working registers
  logic [31:0] pk;
  logic [63:0] prod;
  logic [31:0] e;
  logic [63:0] r;
  logic [63:0] b;

  logic [63:0] m_acc, m_a, m_b;
  logic [5:0]  m_cnt;
  logic        m_busy;

  logic [63:0] d_rem, d_quo, d_div;
  logic [5:0]  d_cnt;
  logic        d_busy;

  logic [63:0] ga, gb;

  function automatic logic [63:0] add_mod(input logic [63:0] x, input logic [63:0] y,
                                          input logic [63:0] n);
    logic [63:0] ny;
    ny = n - y;
    return (x >= ny) ? (x - ny) : (x + y);
  endfunction

  // start command bounds
  logic        mod_bad;
  logic [31:0] b1_dflt, b1_pre, b1_eff;
  logic        clip;
  logic [38:0] b2_mul, b2_cap, b2_eff;

  assign mod_bad = (modulus <= 64'd3) || !modulus[0];

  always_comb begin
    b1_dflt = pm1_pkg::DEF_BOUND_ONE;
    if (prime_limit != 32'd0 && prime_limit < pm1_pkg::DEF_BOUND_ONE) begin
      b1_dflt = prime_limit;
    end
    b1_pre = (bound_one == 32'd0) ? b1_dflt : bound_one;
    clip   = (prime_limit != 32'd0) && (b1_pre > prime_limit);
    b1_eff = clip ? prime_limit : b1_pre;
    b2_mul = {7'd0, b1_eff} * pm1_pkg::B2_MULT;
    b2_cap = (b2_mul > pm1_pkg::MAX_BOUND_TWO) ? pm1_pkg::MAX_BOUND_TWO : b2_mul;
    b2_eff = (b2_cap > {7'd0, prime_limit}) ? {7'd0, prime_limit} : b2_cap;
  end

  // modmul step: one multiplier bit per cycle while the multiplier is busy
  logic [63:0] m_dbl, m_step;
  assign m_dbl  = add_mod(m_acc, m_acc, modulus);
  assign m_step = m_b[63] ? add_mod(m_dbl, m_a, modulus) : m_dbl;

  // divider step: one quotient bit per cycle while the divider is busy
  logic [64:0] d_sh, d_sub;
  logic        d_ge;
  assign d_sh  = {d_rem, d_quo[63]};
  assign d_ge  = d_sh >= {1'b0, d_div};
  assign d_sub = d_sh - {1'b0, d_div};

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= '0;
      bound_one   <= '0;
      prime_limit <= '0;
      phase       <= pm1_pkg::PH_IDLE;
      eb1         <= '0;
      eb2         <= '0;
      clipped     <= 1'b0;
      base        <= pm1_pkg::START_BASE;
      m_busy      <= 1'b0;
      d_busy      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pm1_pkg::CFG_MODULUS:     modulus     <= cfg_data;
          pm1_pkg::CFG_BOUND_ONE:   bound_one   <= cfg_data[31:0];
          pm1_pkg::CFG_PRIME_LIMIT: prime_limit <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.do_start) begin
        base <= pm1_pkg::START_BASE;
        if (mod_bad || prime_limit == 32'd0) begin
          phase   <= pm1_pkg::PH_IDLE;
          clipped <= 1'b0;
        end else begin
          phase   <= pm1_pkg::PH_ONE;
          clipped <= clip;
          eb1     <= b1_eff;
          eb2     <= b2_eff[31:0];
        end
      end
      if (cmd.phase_we) begin
        phase <= cmd.phase_val;
      end
      if (cmd.base_load) begin
        base <= r;
      end
      if (cmd.mul_go) begin
        m_busy <= 1'b1;
      end else if (m_busy && m_cnt == 6'd0) begin
        m_busy <= 1'b0;
      end
      if (cmd.div_go) begin
        d_busy <= 1'b1;
      end else if (d_busy && d_cnt == 6'd0) begin
        d_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd       <= item.cmd;
      it_prime     <= item.prime;
      it_last      <= item.last;
      res_status   <= pm1_pkg::ST_SEARCHING;
      res_factor   <= '0;
      res_cofactor <= '0;
    end
    if (cmd.do_start) begin
      if (mod_bad) begin
        res_status <= pm1_pkg::ST_BADMOD;
      end else if (prime_limit == 32'd0) begin
        res_status <= pm1_pkg::ST_UNAVAIL;
      end else begin
        res_status <= pm1_pkg::ST_SEARCHING;
      end
    end
    if (cmd.res_we) begin
      res_status <= cmd.res_code;
    end
    if (cmd.found_we) begin
      res_factor   <= gb;
      res_cofactor <= d_quo;
    end

    // prime power
    if (cmd.pk_load) begin
      pk <= it_prime;
    end else if (cmd.pk_take) begin
      pk <= prod[31:0];
    end
    if (cmd.prod_calc) begin
      prod <= {32'd0, pk} * {32'd0, it_prime};
    end

    // exponent
    if (cmd.e_load_pk) begin
      e <= pk;
    end else if (cmd.e_load_p) begin
      e <= it_prime;
    end else if (cmd.e_drop_lsb) begin
      e[0] <= 1'b0;
    end else if (cmd.e_shift) begin
      e <= {1'b0, e[31:1]};
    end else if (cmd.e_clr) begin
      e <= '0;
    end

    if (cmd.pow_init) begin
      r <= 64'd1;
    end else if (cmd.r_load) begin
      r <= m_acc;
    end
    if (cmd.b_load_rem) begin
      b <= d_rem;
    end else if (cmd.b_load) begin
      b <= m_acc;
    end

    // modular multiply
    if (cmd.mul_go) begin
      m_acc <= '0;
      m_a   <= cmd.mul_sq ? b : r;
      m_b   <= b;
      m_cnt <= 6'd63;
    end else if (m_busy) begin
      m_acc <= m_step;
      m_b   <= {m_b[62:0], 1'b0};
      m_cnt <= m_cnt - 6'd1;
    end

    // divider: base mod n, or n / g
    if (cmd.div_go) begin
      d_rem <= '0;
      d_quo <= cmd.div_quot ? modulus : base;
      d_div <= cmd.div_quot ? gb : modulus;
      d_cnt <= 6'd63;
    end else if (d_busy) begin
      d_rem <= d_ge ? d_sub[63:0] : d_sh[63:0];
      d_quo <= {d_quo[62:0], d_ge};
      d_cnt <= d_cnt - 6'd1;
    end

    // binary gcd against the odd modulus
    if (cmd.gcd_init) begin
      ga <= (r != 64'd0) ? (r - 64'd1) : (modulus - 64'd1);
      gb <= modulus;
    end else if (cmd.gcd_step) begin
      if (!ga[0]) begin
        ga <= {1'b0, ga[63:1]};
      end else if (ga >= gb) begin
        ga <= ga - gb;
      end else begin
        ga <= gb - ga;
        gb <= ga;
      end
    end
  end

  always_comb begin
    stat.item_cmd   = it_cmd;
    stat.item_last  = it_last;
    stat.phase      = phase;
    stat.mod_bad    = mod_bad;
    stat.p_le_b1    = it_prime <= eb1;
    stat.p_lt2      = it_prime < 32'd2;
    stat.b2_le_b1   = eb2 <= eb1;
    stat.p_gt_b2    = it_prime > eb2;
    stat.prod_le_b1 = prod <= {32'd0, eb1};
    stat.e_zero     = e == 32'd0;
    stat.e_lsb      = e[0];
    stat.e_hi_zero  = e[31:1] == 31'd0;
    stat.mul_busy   = m_busy;
    stat.div_busy   = d_busy;
    stat.a_zero     = ga == 64'd0;
    stat.g_proper   = (gb > 64'd1) && (gb < modulus);
    stat.g_eq_n     = gb == modulus;
  end

  always_comb begin
    result.status        = res_status;
    result.factor        = res_factor;
    result.cofactor      = res_cofactor;
    result.bound_clipped = clipped;
  end

endmodule
